// ===== hdl/conv3x3_same_pad_int8_defines.svh =====
// assertion macros shared by the conv3x3 blocks
`ifndef CONV3X3_SAME_PAD_INT8_DEFINES_SVH
`define CONV3X3_SAME_PAD_INT8_DEFINES_SVH

`ifndef SYNTH
`define C3P_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define C3P_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define C3P_ASSERT_NEVER(label, clk, rst, cond, msg)
`define C3P_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/c3p_pkg.sv =====
`default_nettype none

package c3p_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SIDE_CFG_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MIDDLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_SIDE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ZERO    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINISH_RELU   = 3'd6;

   // one window column, index is the row (0 = oldest)
   typedef logic [2:0][7:0] col_type;
   // [kernel row][kernel column]
   typedef logic [2:0][2:0][7:0] win_type;

   typedef struct packed {
      win_type win;
      logic    last;
      logic    plane_done;
   } job_type;

   typedef struct packed {
      logic [2:0][CSR_DATA_W-1:0] kernel;   // [0] top row, left tap in low byte
      logic [7:0]                 bias;
      logic [SIDE_CFG_W-1:0]      image_side;
      logic                       start_from_zero;
      logic                       finish_with_relu;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/c3p_ram.sv =====
`default_nettype none

module c3p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read during write to the same address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/c3p_fifo.sv =====
`default_nettype none
`include "conv3x3_same_pad_int8_defines.svh"

module c3p_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  valid
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full     = (count_ff == NW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `C3P_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, push && full, "job queue overflow")
   `C3P_ASSERT_NEVER(a_fifo_no_underflow, clock, reset, pop && !valid, "job queue underflow")

endmodule

`default_nettype wire

// ===== hdl/c3p_front.sv =====
`default_nettype none
`include "conv3x3_same_pad_int8_defines.svh"

module c3p_front #(
   parameter int MAX_SIDE = 256,
   localparam int CW = $clog2(MAX_SIDE)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire c3p_pkg::cfg_type  cfg,
   input  wire logic              clr_busy,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] pixel
   output logic                   q_push,
   input  wire logic              q_full,
   output logic [CW-1:0]          job_row,
   output logic [CW-1:0]          job_col,
   output c3p_pkg::job_type       job
);

   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int EW = (SW > c3p_pkg::SIDE_CFG_W) ? SW : c3p_pkg::SIDE_CFG_W;

   // result kinds released by one pixel, in output order
   localparam logic [1:0] KIND_ABOVE_PREV = 2'd0;   // (r-1, c-1)
   localparam logic [1:0] KIND_ABOVE_END  = 2'd1;   // (r-1, side-1)
   localparam logic [1:0] KIND_LAST_PREV  = 2'd2;   // (r, c-1) in the last row
   localparam logic [1:0] KIND_LAST_END   = 2'd3;   // (r, side-1) in the last row

   logic [EW-1:0] side_cfg;
   logic [SW-1:0] side, side_m1, col_inc, row_inc;
   logic [CW-1:0] row_ff, row_in, col_ff, col_in, row_cur, col_cur;
   logic          accept, f_done;
   logic [3:0]    pend_new, sel_mask, rest;
   logic [1:0]    kind;

   logic          f_v_ff;
   logic [3:0]    f_pend_ff;
   logic [7:0]    f_pix_ff;
   logic [CW-1:0] f_row_ff, f_col_ff;

   c3p_pkg::col_type win_left_ff, win_mid_ff;
   c3p_pkg::col_type left, mid, cur, src0, src1, src2;

   logic [15:0] line_rd, line_q, line_wr_data, lfwd_data_ff;
   logic        lfwd_ff, line_wr_en;

   // clamp the configured side into 1..MAX_SIDE
   always_comb begin
      side_cfg = EW'(cfg.image_side);
      if (side_cfg == '0) begin
         side = SW'(1);
      end else if (side_cfg > EW'(MAX_SIDE)) begin
         side = SW'(MAX_SIDE);
      end else begin
         side = SW'(side_cfg);
      end
      side_m1 = side - SW'(1);
   end

   always_comb begin
      row_cur  = (SW'(row_ff) >= side) ? '0 : row_ff;
      col_cur  = (SW'(col_ff) >= side) ? '0 : col_ff;
      col_inc  = SW'(col_cur) + SW'(1);
      row_inc  = SW'(row_cur) + SW'(1);
      row_in   = row_ff;
      col_in   = col_ff;
      if (accept) begin
         row_in = row_cur;
         col_in = CW'(col_inc);
         if (col_inc >= side) begin
            col_in = '0;
            row_in = (row_inc >= side) ? '0 : CW'(row_inc);
         end
      end
      pend_new[KIND_ABOVE_PREV] = (row_cur != '0) && (col_cur != '0);
      pend_new[KIND_ABOVE_END]  = (row_cur != '0) && (SW'(col_cur) == side_m1);
      pend_new[KIND_LAST_PREV]  = (SW'(row_cur) == side_m1) && (col_cur != '0);
      pend_new[KIND_LAST_END]   = (SW'(row_cur) == side_m1) && (SW'(col_cur) == side_m1);
   end

   // window of the pixel in the front stage
   always_comb begin
      line_q = lfwd_ff ? lfwd_data_ff : line_rd;
      left   = (f_col_ff == '0) ? '0 : win_left_ff;
      mid    = (f_col_ff == '0) ? '0 : win_mid_ff;
      cur[0] = (f_row_ff > CW'(1)) ? line_q[15:8] : 8'd0;
      cur[1] = (f_row_ff != '0) ? line_q[7:0] : 8'd0;
      cur[2] = f_pix_ff;
   end

   always_comb begin
      if (f_pend_ff[KIND_ABOVE_PREV]) begin
         kind = KIND_ABOVE_PREV;
      end else if (f_pend_ff[KIND_ABOVE_END]) begin
         kind = KIND_ABOVE_END;
      end else if (f_pend_ff[KIND_LAST_PREV]) begin
         kind = KIND_LAST_PREV;
      end else begin
         kind = KIND_LAST_END;
      end
      sel_mask   = 4'b0001 << kind;
      rest       = f_pend_ff & ~sel_mask;
      q_push     = f_v_ff && (f_pend_ff != '0) && !q_full;
      f_done     = f_v_ff && ((f_pend_ff == '0) || (q_push && (rest == '0)));
      req_tready = !clr_busy && (!f_v_ff || f_done);
      accept     = req_tvalid && req_tready;
   end

   // odd kinds sit on the right edge: columns (mid, cur, pad)
   // upper kinds drop the top row and pad below
   always_comb begin
      src0 = kind[0] ? mid : left;
      src1 = kind[0] ? cur : mid;
      src2 = kind[0] ? '0 : cur;
      if (kind[1]) begin
         job.win[0] = {src2[1], src1[1], src0[1]};
         job.win[1] = {src2[2], src1[2], src0[2]};
         job.win[2] = '0;
      end else begin
         job.win[0] = {src2[0], src1[0], src0[0]};
         job.win[1] = {src2[1], src1[1], src0[1]};
         job.win[2] = {src2[2], src1[2], src0[2]};
      end
      job.last       = (rest == '0);
      job.plane_done = (kind == KIND_LAST_END);
      job_row        = kind[1] ? f_row_ff : f_row_ff - CW'(1);
      job_col        = kind[0] ? f_col_ff : f_col_ff - CW'(1);
   end

   // both line buffers share one word: [7:0] row above, [15:8] two above
   assign line_wr_en   = f_done;
   assign line_wr_data = {line_q[7:0], f_pix_ff};

   c3p_ram #(
      .WIDTH (16),
      .DEPTH (MAX_SIDE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (f_col_ff),
      .wr_data (line_wr_data),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         f_v_ff      <= 1'b0;
         f_pend_ff   <= '0;
         win_left_ff <= '0;
         win_mid_ff  <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         if (accept) begin
            f_v_ff    <= 1'b1;
            f_pend_ff <= pend_new;
         end else if (f_done) begin
            f_v_ff    <= 1'b0;
            f_pend_ff <= '0;
         end else if (q_push) begin
            f_pend_ff <= rest;
         end
         if (f_done) begin
            win_left_ff <= mid;
            win_mid_ff  <= cur;
         end
      end
   end

   // write and read of the same column in one cycle: take the written word
   always_ff @(posedge clock) begin
      if (accept) begin
         f_pix_ff     <= req_tdata;
         f_row_ff     <= row_cur;
         f_col_ff     <= col_cur;
         lfwd_ff      <= line_wr_en && (f_col_ff == col_cur);
         lfwd_data_ff <= line_wr_data;
      end
   end

   `C3P_ASSERT_NEVER(a_front_pend_needs_item, clock, reset, !f_v_ff && (f_pend_ff != '0), "pending results without a pixel")

endmodule

`default_nettype wire

// ===== hdl/c3p_back.sv =====
`default_nettype none
`include "conv3x3_same_pad_int8_defines.svh"

module c3p_back #(
   parameter int MAX_SIDE = 256,
   localparam int CW = $clog2(MAX_SIDE)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire c3p_pkg::cfg_type  cfg,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire logic [CW-1:0]     job_row,
   input  wire logic [CW-1:0]     job_col,
   input  wire c3p_pkg::job_type  job,
   output logic                   clr_busy,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,   // [7:0] out_row, [15:8] out_col, [23:16] value
   output logic                   rsp_tlast,   // last_of_run
   output logic                   rsp_tuser    // [0] plane_done
);

   localparam int ACC_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW        = $clog2(ACC_DEPTH);

   logic en;

   // product stage
   logic              p_v_ff;
   c3p_pkg::win_type  p_prod_ff, prod;
   logic [AW-1:0]     p_addr_ff;
   logic [7:0]        p_row_ff, p_col_ff;
   logic              p_last_ff, p_pd_ff;

   // sum stage, accumulator word arrives here
   logic              s_v_ff;
   logic [7:0]        s_sum_ff, sum;
   logic [AW-1:0]     s_addr_ff;
   logic [7:0]        s_row_ff, s_col_ff;
   logic              s_last_ff, s_pd_ff;

   logic [7:0]        acc_rd, acc_old, acc_base, acc_biased, acc_new;
   logic              afwd_ff;
   logic [7:0]        afwd_data_ff;

   logic              clr_busy_ff;
   logic [AW-1:0]     clr_addr_ff;

   logic              acc_wr_en;
   logic [AW-1:0]     acc_wr_addr;
   logic [7:0]        acc_wr_data;

   logic              rsp_tvalid_ff, rsp_tlast_ff, rsp_tuser_ff;
   logic [7:0]        rsp_row_ff, rsp_col_ff, rsp_value_ff;

   assign en    = !rsp_tvalid_ff || rsp_tready;
   assign q_pop = en && q_valid && !clr_busy_ff;

   // low byte of each product is all that survives the int8 wrap
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            prod[k][j] = job.win[k][j] * cfg.kernel[k][8*j +: 8];
         end
      end
   end

   always_comb begin
      sum = 8'd0;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            sum = sum + p_prod_ff[k][j];
         end
      end
   end

   always_comb begin
      acc_old    = afwd_ff ? afwd_data_ff : acc_rd;
      acc_base   = s_sum_ff + (cfg.start_from_zero ? 8'd0 : acc_old);
      acc_biased = cfg.finish_with_relu ? acc_base + cfg.bias : acc_base;
      acc_new    = (cfg.finish_with_relu && acc_biased[7]) ? 8'd0 : acc_biased;
   end

   always_comb begin
      acc_wr_en   = clr_busy_ff || (en && s_v_ff);
      acc_wr_addr = clr_busy_ff ? clr_addr_ff : s_addr_ff;
      acc_wr_data = clr_busy_ff ? 8'd0 : acc_new;
   end

   c3p_ram #(
      .WIDTH (8),
      .DEPTH (ACC_DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (en && p_v_ff),
      .rd_addr (p_addr_ff),
      .rd_data (acc_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff        <= 1'b0;
         s_v_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         afwd_ff       <= 1'b0;
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         if (en) begin
            p_v_ff        <= q_pop;
            s_v_ff        <= p_v_ff;
            rsp_tvalid_ff <= s_v_ff;
            // back-to-back results on one position (side of one)
            afwd_ff       <= s_v_ff && p_v_ff && (s_addr_ff == p_addr_ff);
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(ACC_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p_prod_ff <= prod;
         p_addr_ff <= AW'(job_row) * AW'(MAX_SIDE) + AW'(job_col);
         p_row_ff  <= 8'(job_row);
         p_col_ff  <= 8'(job_col);
         p_last_ff <= job.last;
         p_pd_ff   <= job.plane_done;
      end
      if (en) begin
         s_sum_ff     <= sum;
         s_addr_ff    <= p_addr_ff;
         s_row_ff     <= p_row_ff;
         s_col_ff     <= p_col_ff;
         s_last_ff    <= p_last_ff;
         s_pd_ff      <= p_pd_ff;
         afwd_data_ff <= acc_new;
      end
      if (en && s_v_ff) begin
         rsp_row_ff   <= s_row_ff;
         rsp_col_ff   <= s_col_ff;
         rsp_value_ff <= acc_new;
         rsp_tlast_ff <= s_last_ff;
         rsp_tuser_ff <= s_pd_ff;
      end
   end

   assign clr_busy   = clr_busy_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `C3P_ASSERT_NEVER(a_back_idle_while_clearing, clock, reset, clr_busy_ff && (p_v_ff || s_v_ff || rsp_tvalid_ff), "result in flight during clearing")
   `C3P_ASSERT_IMPLY(a_back_plane_done_is_last, clock, reset, rsp_tvalid_ff && rsp_tuser_ff, rsp_tlast_ff, "plane end not last of run")

endmodule

`default_nettype wire

// ===== hdl/conv3x3_same_pad_int8.sv =====
// 3x3 cross-correlation with zero padding on one square int8 plane, accumulated
// into a stored plane so several input channels can be summed over passes.
// req: one pixel per transfer, row-major. rsp: finished output pixels with
// row, column and the new accumulator value; tlast marks the last result of
// the pixel that released it, tuser marks the bottom-right pixel.
// csr: register writes (index, data); take them only while the block is idle.
// Throughput: one pixel per cycle while the job queue has room; a pixel that releases k results (up to four
// at the plane corner) holds req_tready low until its last job is queued, since the
// front stage hands one result job per cycle to the queue.
// Results leave at one per cycle while the receiver is ready, each reading and writing the accumulator RAM.
// Path: front stage, job queue, product stage, sum stage, then the rsp output register.
// Reset: counters, window and config return to defaults, then the accumulator
// plane is zeroed, one word a cycle over all MAX_SIDE*MAX_SIDE words (65536 at the
// default), with req_tready low; csr writes are taken throughout.
// Receiver stall: the result stays in the output register, up to four jobs
// queue behind the pipeline, then req_tready drops.
`default_nettype none

module conv3x3_same_pad_int8 #(
   parameter int MAX_SIDE = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [c3p_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [c3p_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] pixel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [23:0]                            rsp_tdata,   // [7:0] out_row, [15:8] out_col, [23:16] value
   output logic                                   rsp_tlast,   // last_of_run
   output logic                                   rsp_tuser    // [0] plane_done
);

   localparam int CW          = $clog2(MAX_SIDE);
   localparam int QUEUE_DEPTH = 4;
   localparam int JOB_W       = 2 * CW + $bits(c3p_pkg::job_type);

   c3p_pkg::cfg_type cfg_ff, cfg_in;

   logic              clr_busy, q_push, q_full, q_pop, q_valid;
   logic [CW-1:0]     push_row, push_col, pop_row, pop_col;
   c3p_pkg::job_type  push_job, pop_job;
   logic [JOB_W-1:0]  push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            c3p_pkg::CSR_KERNEL_TOP:    cfg_in.kernel[0]        = csr_data;
            c3p_pkg::CSR_KERNEL_MIDDLE: cfg_in.kernel[1]        = csr_data;
            c3p_pkg::CSR_KERNEL_BOTTOM: cfg_in.kernel[2]        = csr_data;
            c3p_pkg::CSR_BIAS:          cfg_in.bias             = csr_data[7:0];
            c3p_pkg::CSR_IMAGE_SIDE:    cfg_in.image_side       =
                                           csr_data[c3p_pkg::SIDE_CFG_W-1:0];
            c3p_pkg::CSR_START_ZERO:    cfg_in.start_from_zero  = csr_data[0];
            c3p_pkg::CSR_FINISH_RELU:   cfg_in.finish_with_relu = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                  <= '0;
         cfg_ff.image_side       <= c3p_pkg::SIDE_CFG_W'(224);
         cfg_ff.start_from_zero  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   c3p_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clr_busy   (clr_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_full     (q_full),
      .job_row    (push_row),
      .job_col    (push_col),
      .job        (push_job)
   );

   assign push_data = {push_row, push_col, push_job};
   assign {pop_row, pop_col, pop_job} = pop_data;

   c3p_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .valid     (q_valid)
   );

   c3p_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .job_row    (pop_row),
      .job_col    (pop_col),
      .job        (pop_job),
      .clr_busy   (clr_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== sim/conv3x3_same_pad_int8_test.sv =====
module conv3x3_same_pad_int8_test;
   import c3p_pkg::*;

   localparam int SIDE_MAX = 256;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS = 100;
   localparam int WIDE_PLANE_PIXELS = 2 * SIDE_MAX + 8;

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] value;
      logic       last;
      logic       done;
   } pixel_out_t;

   typedef int trio_t [3];

   typedef enum logic {STEP_CSR, STEP_PIXEL} step_kind_t;

   typedef struct packed {
      step_kind_t             kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;    // register value, or the pixel in [7:0]
      logic                   known;   // single-pixel plane with a typed-in value
      logic [7:0]             value;
   } step_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [23:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   // predictor copy of the registers and the block state
   logic [CSR_DATA_W-1:0] kern [3];
   logic [7:0]            bias_cfg;
   logic [8:0]            side_cfg;
   logic                  zero_start_cfg;
   logic                  relu_cfg;
   logic [7:0]            row_above [SIDE_MAX];
   logic [7:0]            row_two_above [SIDE_MAX];
   int                    fill_depth [SIDE_MAX];
   logic [7:0]            window_cols [6];
   int                    row_pos;
   int                    col_pos;
   logic [7:0]            acc_plane [SIDE_MAX*SIDE_MAX];

   pixel_out_t expected_q [$];
   pixel_out_t fresh [$];
   step_t      script [$];

   int errors;
   int reports;
   int send_idle_pct;
   int stall_pct;
   int cycle_count;

   conv3x3_same_pad_int8 dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("conv3x3_same_pad_int8_test: errors");
         $finish;
      end
   end

   function automatic int sx8(input logic [7:0] v);
      return int'($signed(v));
   endfunction

   function automatic int kernel_tap(input int k, input int j);
      return sx8(kern[k][8*j +: 8]);
   endfunction

   // shift 1 moves the kernel up one row, bottom padding below the last image row
   function automatic int window_sum(input trio_t a, input trio_t b, input trio_t d,
                                     input int shift);
      int sum;
      int k;
      sum = 0;
      for (k = 0; k + shift < 3; k++)
         sum += kernel_tap(k, 0) * a[k+shift] + kernel_tap(k, 1) * b[k+shift]
                + kernel_tap(k, 2) * d[k+shift];
      return sum;
   endfunction

   function automatic pixel_out_t finish_pixel(input int r, input int c, input int s,
                                               input int sum);
      logic [7:0] acc;
      pixel_out_t res;
      int         idx;
      idx = r * SIDE_MAX + c;
      acc = sum[7:0];
      if (!zero_start_cfg)
         acc = acc + acc_plane[idx];
      if (relu_cfg) begin
         acc = acc + bias_cfg;
         if (acc[7])
            acc = 8'd0;
      end
      acc_plane[idx] = acc;
      res.row = r[7:0];
      res.col = c[7:0];
      res.value = acc;
      res.last = 1'b0;
      res.done = (r == s - 1) && (c == s - 1);
      return res;
   endfunction

   task automatic predict_pixel(input logic [7:0] px);
      int         s;
      int         r;
      int         c;
      int         k;
      trio_t      left;
      trio_t      mid;
      trio_t      cur;
      trio_t      pad;
      pixel_out_t tail;
      fresh.delete();
      s = side_cfg;
      if (s < 1)
         s = 1;
      if (s > SIDE_MAX)
         s = SIDE_MAX;
      if (row_pos >= s)
         row_pos = 0;
      if (col_pos >= s)
         col_pos = 0;
      r = row_pos;
      c = col_pos;
      if (c == 0)
         for (k = 0; k < 6; k++)
            window_cols[k] = 8'd0;
      cur[0] = (r >= 2) ? sx8(row_two_above[c]) : 0;
      cur[1] = (r >= 1) ? sx8(row_above[c]) : 0;
      cur[2] = sx8(px);
      for (k = 0; k < 3; k++) begin
         left[k] = sx8(window_cols[k]);
         mid[k] = sx8(window_cols[3+k]);
         pad[k] = 0;
      end
      if (r >= 1 && c >= 1)
         fresh.push_back(finish_pixel(r - 1, c - 1, s, window_sum(left, mid, cur, 0)));
      if (r >= 1 && c == s - 1)
         fresh.push_back(finish_pixel(r - 1, c, s, window_sum(mid, cur, pad, 0)));
      if (r == s - 1 && c >= 1)
         fresh.push_back(finish_pixel(r, c - 1, s, window_sum(left, mid, cur, 1)));
      if (r == s - 1 && c == s - 1)
         fresh.push_back(finish_pixel(r, c, s, window_sum(mid, cur, pad, 1)));
      if (fresh.size() > 0) begin
         tail = fresh.pop_back();
         tail.last = 1'b1;
         fresh.push_back(tail);
      end
      row_two_above[c] = row_above[c];
      row_above[c] = px;
      if (fill_depth[c] < 2)
         fill_depth[c]++;
      for (k = 0; k < 3; k++) begin
         window_cols[k] = window_cols[3+k];
         window_cols[3+k] = cur[k][7:0];
      end
      col_pos = c + 1;
      if (col_pos >= s) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= s)
            row_pos = 0;
      end
   endtask

   // widest side whose line buffer columns both hold written data
   function automatic int safe_width();
      int w;
      w = 0;
      while (w < SIDE_MAX && fill_depth[w] >= 2)
         w++;
      return w;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_kernel();
      case ($urandom_range(7))
         0: return 24'h000000;
         1: return 24'h808080;
         2: return 24'h7F7F7F;
         3: return 24'hFFFFFF;
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(7))
         0: return 8'h80;
         1: return 8'h7F;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic note_error(input string what, input pixel_out_t want, input pixel_out_t got);
      errors++;
      if (reports < MAX_REPORTS) begin
         reports++;
         $display("%0t %s: expected row %0d col %0d value %0d last %0b done %0b, got row %0d col %0d value %0d last %0b done %0b",
                  $time, what, want.row, want.col, $signed(want.value), want.last, want.done,
                  got.row, got.col, $signed(got.value), got.last, got.done);
      end
   endtask

   always @(posedge clock) begin : check_results
      pixel_out_t want;
      pixel_out_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row = rsp_tdata[7:0];
         got.col = rsp_tdata[15:8];
         got.value = rsp_tdata[23:16];
         got.last = rsp_tlast;
         got.done = rsp_tuser;
         if (expected_q.size() == 0) begin
            note_error("result with nothing pending", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got.row !== want.row || got.col !== want.col || got.value !== want.value
                || got.last !== want.last || got.done !== want.done)
               note_error("result mismatch", want, got);
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val, input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      // keep valid up when another write follows at once
      if (!more)
         csr_valid <= 1'b0;
      case (idx)
         CSR_KERNEL_TOP:    kern[0] = val;
         CSR_KERNEL_MIDDLE: kern[1] = val;
         CSR_KERNEL_BOTTOM: kern[2] = val;
         CSR_BIAS:          bias_cfg = val[7:0];
         CSR_IMAGE_SIDE:    side_cfg = val[SIDE_CFG_W-1:0];
         CSR_START_ZERO:    zero_start_cfg = val[0];
         CSR_FINISH_RELU:   relu_cfg = val[0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [7:0] px, input logic known, input logic [7:0] value);
      pixel_out_t typed;
      int         k;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_pixel(px);
      if (known) begin
         typed.row = 8'd0;
         typed.col = 8'd0;
         typed.value = value;
         typed.last = 1'b1;
         typed.done = 1'b1;
         expected_q.push_back(typed);
      end else begin
         for (k = 0; k < fresh.size(); k++)
            expected_q.push_back(fresh[k]);
      end
   endtask

   // pixels that release nothing may still be in flight after the last result
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_settings(input int s);
      write_reg(CSR_KERNEL_TOP, random_kernel(), 1'b1);
      write_reg(CSR_KERNEL_MIDDLE, random_kernel(), 1'b1);
      write_reg(CSR_KERNEL_BOTTOM, random_kernel(), 1'b1);
      write_reg(CSR_BIAS, CSR_DATA_W'($urandom_range(255)), 1'b1);
      write_reg(CSR_IMAGE_SIDE, CSR_DATA_W'(s), 1'b1);
      write_reg(CSR_START_ZERO, CSR_DATA_W'($urandom_range(1)), 1'b1);
      write_reg(CSR_FINISH_RELU, CSR_DATA_W'($urandom_range(1)), 1'b0);
   endtask

   task automatic random_phase(input int send_pct, input int stall, input int budget);
      int sent;
      int s;
      int e;
      int lim;
      int n;
      int k;
      send_idle_pct = send_pct;
      stall_pct = stall;
      sent = 0;
      while (sent < budget) begin
         drain();
         s = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         lim = safe_width();
         // mid-plane resize must not reach line buffer columns never filled
         if ((row_pos != 0 || col_pos != 0) && s > lim)
            s = (lim > 0) ? lim : 1;
         random_settings(s);
         e = (s < 1) ? 1 : s;
         n = e * e;
         if (n > 1 && $urandom_range(3) == 0)
            n = $urandom_range(1, n - 1);
         for (k = 0; k < n; k++)
            send_pixel(random_pixel(), 1'b0, 8'd0);
         sent += n;
      end
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      step_t st;
      st.kind = STEP_CSR;
      st.index = idx;
      st.data = val;
      st.known = 1'b0;
      st.value = 8'd0;
      script.push_back(st);
   endtask

   task automatic add_pixel(input logic [7:0] px, input logic known, input logic [7:0] value);
      step_t st;
      st.kind = STEP_PIXEL;
      st.index = '0;
      st.data = CSR_DATA_W'(px);
      st.known = known;
      st.value = value;
      script.push_back(st);
   endtask

   initial begin : stimulus
      int    i;
      bit    dirty;
      bit    more;
      step_t st;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      rsp_tready = 1'b1;
      errors = 0;
      reports = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      cycle_count = 0;
      for (i = 0; i < 3; i++)
         kern[i] = '0;
      bias_cfg = 8'd0;
      side_cfg = 9'd224;
      zero_start_cfg = 1'b1;
      relu_cfg = 1'b0;
      for (i = 0; i < SIDE_MAX; i++) begin
         row_above[i] = 8'd0;
         row_two_above[i] = 8'd0;
         fill_depth[i] = 0;
      end
      for (i = 0; i < 6; i++)
         window_cols[i] = 8'd0;
      for (i = 0; i < SIDE_MAX * SIDE_MAX; i++)
         acc_plane[i] = 8'd0;
      row_pos = 0;
      col_pos = 0;

      // one-pixel planes first: kernel still zero after reset
      add_csr(CSR_IMAGE_SIDE, 24'd1);
      add_pixel(8'h7F, 1'b1, 8'h00);
      add_csr(CSR_KERNEL_MIDDLE, 24'h000100);
      add_pixel(8'h80, 1'b1, 8'h80);
      add_pixel(8'h7F, 1'b1, 8'h7F);
      // accumulate onto the stored value, then bias and clamp
      add_csr(CSR_START_ZERO, 24'd0);
      add_csr(CSR_FINISH_RELU, 24'd1);
      add_csr(CSR_BIAS, 24'h00007F);
      add_pixel(8'h01, 1'b1, 8'h00);
      add_pixel(8'hFF, 1'b0, 8'h00);
      add_csr(CSR_BIAS, 24'h000080);
      add_csr(CSR_START_ZERO, 24'd1);
      add_pixel(8'h7F, 1'b0, 8'h00);
      add_pixel(8'h00, 1'b0, 8'h00);
      // side zero behaves as side one
      add_csr(CSR_IMAGE_SIDE, 24'd0);
      add_pixel(8'h55, 1'b0, 8'h00);
      // full 3x3 plane with extreme taps and pixels
      add_csr(CSR_KERNEL_TOP, 24'hFFFFFF);
      add_csr(CSR_KERNEL_MIDDLE, 24'h7F807F);
      add_csr(CSR_KERNEL_BOTTOM, 24'h80017F);
      add_csr(CSR_BIAS, 24'h0000F6);
      add_csr(CSR_FINISH_RELU, 24'd0);
      add_csr(CSR_START_ZERO, 24'd0);
      add_csr(CSR_IMAGE_SIDE, 24'd3);
      add_pixel(8'h80, 1'b0, 8'h00);
      add_pixel(8'h7F, 1'b0, 8'h00);
      add_pixel(8'h00, 1'b0, 8'h00);
      add_pixel(8'hFF, 1'b0, 8'h00);
      add_pixel(8'h01, 1'b0, 8'h00);
      add_pixel(8'h80, 1'b0, 8'h00);
      add_pixel(8'h7F, 1'b0, 8'h00);
      add_pixel(8'h80, 1'b0, 8'h00);
      add_pixel(8'h7F, 1'b0, 8'h00);
      // stop mid-row, then shrink the side so the column counter wraps to zero
      add_pixel(8'h12, 1'b0, 8'h00);
      add_pixel(8'hFD, 1'b0, 8'h00);
      add_csr(CSR_IMAGE_SIDE, 24'd2);
      add_csr(CSR_FINISH_RELU, 24'd1);
      add_csr(CSR_BIAS, 24'h000005);
      // bottom-right pixel of a 2x2 plane releases four results
      add_pixel(8'h7F, 1'b0, 8'h00);
      add_pixel(8'h80, 1'b0, 8'h00);
      add_pixel(8'h40, 1'b0, 8'h00);
      add_pixel(8'hC0, 1'b0, 8'h00);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      dirty = 1'b0;
      for (i = 0; i < script.size(); i++) begin
         st = script[i];
         if (st.kind == STEP_CSR) begin
            if (dirty) begin
               drain();
               dirty = 1'b0;
            end
            more = (i + 1 < script.size()) && (script[i+1].kind == STEP_CSR);
            write_reg(st.index, st.data, more);
         end else begin
            send_pixel(st.data[7:0], st.known, st.value);
            dirty = 1'b1;
         end
      end

      // widest plane: side above the maximum clamps, two rows and a bit
      drain();
      write_reg(CSR_IMAGE_SIDE, 24'd256, 1'b1);
      write_reg(CSR_IMAGE_SIDE, 24'h0001FF, 1'b1);
      write_reg(CSR_KERNEL_TOP, random_kernel(), 1'b1);
      write_reg(CSR_KERNEL_MIDDLE, random_kernel(), 1'b1);
      write_reg(CSR_KERNEL_BOTTOM, random_kernel(), 1'b1);
      write_reg(CSR_START_ZERO, 24'd0, 1'b0);
      for (i = 0; i < WIDE_PLANE_PIXELS; i++)
         send_pixel(random_pixel(), 1'b0, 8'd0);

      random_phase(0, 0, 30);
      random_phase(84, 0, 30);
      random_phase(0, 84, 30);
      random_phase(37, 37, 30);
      drain();

      if (errors == 0)
         $display("conv3x3_same_pad_int8_test: clean");
      else
         $display("conv3x3_same_pad_int8_test: errors");
      $finish;
   end

endmodule
